>>> rtl/ees_pkg.sv
package ees_pkg;

    localparam int POS_W       = 32;
    localparam int EDGE_W      = 16;
    localparam int SCALE_W     = 24;
    localparam int MUL_W       = EDGE_W + SCALE_W;
    localparam int FRAC_SHIFT  = 8;
    localparam int SAMP_W      = MUL_W - FRAC_SHIFT + 1;
    localparam int DIV_STEPS   = 4;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;
    localparam logic [EDGE_W-1:0]  EDGE_MAX    = 16'hFFFF;

    typedef enum logic [1:0] {
        REQ_EDGE  = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_CLEAR = 2'd2
    } req_t;

    typedef logic [1:0] cnt_addr_t;

    localparam cnt_addr_t CNT_1A = 2'd0;
    localparam cnt_addr_t CNT_1B = 2'd1;
    localparam cnt_addr_t CNT_2A = 2'd2;
    localparam cnt_addr_t CNT_2B = 2'd3;

    typedef logic signed [SAMP_W-1:0] sample_t;

    // Q.16 product truncated to Q.8, signed by the direction level
    function automatic sample_t make_sample(logic [MUL_W-1:0] prod, logic dir_high);
        sample_t mag;
        mag = sample_t'({1'b0, prod[MUL_W-1:FRAC_SHIFT]});
        return dir_high ? mag : -mag;
    endfunction

endpackage

>>> rtl/ees_div.sv
module ees_div #(
    parameter int NUM_W = 37,
    parameter int DEN_W = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [NUM_W-1:0]         num,
    input  logic        [DEN_W-1:0]         den,
    output logic                            busy,
    output logic signed [ees_pkg::SAMP_W-1:0] quo
);

    localparam int STEPS  = ees_pkg::DIV_STEPS;
    localparam int OUT_W  = ees_pkg::SAMP_W;
    localparam int CYC    = (NUM_W + STEPS - 1) / STEPS;
    localparam int ITER_W = CYC * STEPS;
    localparam int CNT_W  = $clog2(CYC + 1);

    logic [ITER_W-1:0] mag_reg;
    logic [ITER_W-1:0] mag_next;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [DEN_W-1:0]  den_reg;
    logic              neg_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NUM_W-1:0]  num_abs;
    logic [DEN_W:0]    trial;
    logic [OUT_W-1:0]  q_mag;

    assign num_abs = num[NUM_W-1] ? (NUM_W'(0) - NUM_W'(num)) : NUM_W'(num);
    assign busy    = cnt_reg != '0;

    // restoring division, STEPS quotient bits per cycle while busy
    always_comb
    begin
        rem_next = rem_reg;
        mag_next = mag_reg;
        trial    = '0;
        for (int i = 0; i < STEPS; i++)
        begin
            trial    = {rem_next, mag_next[ITER_W-1]};
            mag_next = {mag_next[ITER_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                trial       = trial - {1'b0, den_reg};
                mag_next[0] = 1'b1;
            end
            rem_next = trial[DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(CYC);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= ITER_W'(num_abs);
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[NUM_W-1];
        end
        else if (busy)
        begin
            mag_reg <= mag_next;
            rem_reg <= rem_next;
        end
    end

    assign q_mag = mag_reg[OUT_W-1:0];
    assign quo   = neg_reg ? -signed'(q_mag) : signed'(q_mag);

endmodule

>>> rtl/encoder_edge_speed_averager_unit.sv
// encoder edge counter and windowed speed averager for two motors
//
// input channel (in_valid / in_stall): one beat per request, req_type
// selects an encoder edge, a period tick or a clear of all counts.
// output channel (out_valid / out_stall): one beat per tick carrying both
// window averages (signed Q.8) and both wrapping positions.
// config channel (cfg_valid / cfg_ready): write of the Q8.16 rpm scale,
// always ready; write it only while the block is quiet.
//
// an edge beat stalls the input while the count memory is written in the
// edge state; a clear beat does not stall. a tick reads the four channel
// counts from the count memory one per cycle, then runs two iterative
// dividers at 4 quotient bits per cycle; once both are done and the output
// register is free, the result is registered and the next beat is
// taken the cycle after. a stalled result is held in the output register
// while new edges and clears are still taken; a following tick waits in
// its last step until the held result leaves.
// reset clears counts, sums, fill level and the scale (to 1.0); window
// memory contents are not cleared and are only read once written.
module encoder_edge_speed_averager_unit #(
    parameter int WINDOW = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          req_type,
    input  logic                                motor_sel,
    input  logic                                channel_sel,
    input  logic                                dir_level_1,
    input  logic                                dir_level_2,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ees_pkg::SAMP_W-1:0]   speed_avg_1,
    output logic signed [ees_pkg::SAMP_W-1:0]   speed_avg_2,
    output logic signed [ees_pkg::POS_W-1:0]    position_1,
    output logic signed [ees_pkg::POS_W-1:0]    position_2,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ees_pkg::SCALE_W-1:0]         cfg_data
);

    localparam int SAMP_W = ees_pkg::SAMP_W;
    localparam int POS_W  = ees_pkg::POS_W;
    localparam int SUM_W  = SAMP_W + $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_EDGE = 7'b0000010,
        ST_POS1 = 7'b0000100,
        ST_POS2 = 7'b0001000,
        ST_POS3 = 7'b0010000,
        ST_POS4 = 7'b0100000,
        ST_WAIT = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic                              in_acc;
    logic [ees_pkg::SCALE_W-1:0]       scale_reg;
    logic [ees_pkg::EDGE_W-1:0]        edges_reg [2];
    logic [ees_pkg::MUL_W-1:0]         mul_reg;
    logic [ees_pkg::EDGE_W-1:0]        mul_a;

    logic [POS_W-1:0]                  cnt_mem [4];
    logic [3:0]                        cnt_vld_reg;
    logic [POS_W-1:0]                  cnt_q_reg;
    logic                              cnt_qv_reg;
    logic [POS_W-1:0]                  cnt_val;
    ees_pkg::cnt_addr_t                cnt_raddr;
    ees_pkg::cnt_addr_t                cnt_waddr_reg;
    logic                              cnt_we;
    logic [POS_W-1:0]                  cnt_wdata;
    logic                              edge_dir_reg;
    logic                              dir1_reg;
    logic                              dir2_reg;

    logic [2*SAMP_W-1:0]               win_mem [WINDOW];
    logic [2*SAMP_W-1:0]               win_q_reg;
    logic                              win_full;
    logic [SLOT_W:0]                   slot_sum;
    logic [SLOT_W:0]                   slot_wrap;
    logic [SLOT_W-1:0]                 slot;
    logic [FILL_W-1:0]                 fill_reg;
    logic [SLOT_W-1:0]                 oldest_reg;

    ees_pkg::sample_t                  samp1_reg;
    ees_pkg::sample_t                  samp2_reg;
    ees_pkg::sample_t                  old1;
    ees_pkg::sample_t                  old2;
    logic signed [SUM_W-1:0]           old1_ext;
    logic signed [SUM_W-1:0]           old2_ext;
    logic signed [SUM_W-1:0]           part1_reg;
    logic signed [SUM_W-1:0]           part2_reg;
    logic signed [SUM_W-1:0]           sum1_reg;
    logic signed [SUM_W-1:0]           sum2_reg;

    logic [POS_W-1:0]                  posa_reg;
    logic [POS_W-1:0]                  pos1_reg;
    logic [POS_W-1:0]                  pos2_reg;

    logic                              div_start;
    logic                              div1_busy;
    logic                              div2_busy;
    ees_pkg::sample_t                  div1_quo;
    ees_pkg::sample_t                  div2_quo;

    logic                              out_valid_reg;
    logic                              out_load;
    ees_pkg::sample_t                  avg1_reg;
    ees_pkg::sample_t                  avg2_reg;
    logic [POS_W-1:0]                  opos1_reg;
    logic [POS_W-1:0]                  opos2_reg;

    assign in_stall  = state_reg != ST_IDLE;
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= ees_pkg::SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            scale_reg <= cfg_data;
        end
    end

    // state machine
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    priority if (ees_pkg::req_t'(req_type) == ees_pkg::REQ_EDGE)
                        state_next = ST_EDGE;
                    else if (ees_pkg::req_t'(req_type) == ees_pkg::REQ_TICK)
                        state_next = ST_POS1;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_EDGE: state_next = ST_IDLE;
            ST_POS1: state_next = ST_POS2;
            ST_POS2: state_next = ST_POS3;
            ST_POS3: state_next = ST_POS4;
            ST_POS4: state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // count memory, read data registered in the cycle after the address
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:
                cnt_raddr = (ees_pkg::req_t'(req_type) == ees_pkg::REQ_EDGE)
                          ? ees_pkg::cnt_addr_t'({motor_sel, channel_sel})
                          : ees_pkg::CNT_1A;
            ST_POS1: cnt_raddr = ees_pkg::CNT_1B;
            ST_POS2: cnt_raddr = ees_pkg::CNT_2A;
            ST_POS3: cnt_raddr = ees_pkg::CNT_2B;
            default: cnt_raddr = ees_pkg::CNT_1A;
        endcase
    end

    assign cnt_val   = cnt_qv_reg ? cnt_q_reg : '0;
    assign cnt_we    = state_reg == ST_EDGE;
    assign cnt_wdata = edge_dir_reg ? (cnt_val - POS_W'(1)) : (cnt_val + POS_W'(1));

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_waddr_reg] <= cnt_wdata;
        cnt_q_reg  <= cnt_mem[cnt_raddr];
        cnt_qv_reg <= cnt_vld_reg[cnt_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_vld_reg  <= '0;
            edges_reg[0] <= '0;
            edges_reg[1] <= '0;
        end
        else
        begin
            if (cnt_we)
                cnt_vld_reg[cnt_waddr_reg] <= 1'b1;
            if (state_reg == ST_POS3)
            begin
                edges_reg[0] <= '0;
                edges_reg[1] <= '0;
            end
            if (in_acc)
            begin
                unique case (ees_pkg::req_t'(req_type))
                    ees_pkg::REQ_EDGE:
                    begin
                        if (edges_reg[motor_sel] != ees_pkg::EDGE_MAX)
                            edges_reg[motor_sel] <= edges_reg[motor_sel]
                                                  + ees_pkg::EDGE_W'(1);
                    end
                    ees_pkg::REQ_CLEAR:
                    begin
                        cnt_vld_reg  <= '0;
                        edges_reg[0] <= '0;
                        edges_reg[1] <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cnt_waddr_reg <= ees_pkg::cnt_addr_t'({motor_sel, channel_sel});
            edge_dir_reg  <= motor_sel ? dir_level_2 : dir_level_1;
            dir1_reg      <= dir_level_1;
            dir2_reg      <= dir_level_2;
        end
    end

    // speed samples through one shared multiplier
    assign mul_a = (state_reg == ST_POS1) ? edges_reg[1] : edges_reg[0];

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * scale_reg;
    end

    // window memory, oldest entry read every cycle
    assign win_full  = fill_reg == FILL_W'(WINDOW);
    assign slot_sum  = (SLOT_W + 1)'(oldest_reg) + (SLOT_W + 1)'(fill_reg);
    assign slot_wrap = (slot_sum >= (SLOT_W + 1)'(WINDOW))
                     ? slot_sum - (SLOT_W + 1)'(WINDOW) : slot_sum;
    assign slot      = win_full ? oldest_reg : slot_wrap[SLOT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_POS3)
            win_mem[slot] <= {samp2_reg, samp1_reg};
        win_q_reg <= win_mem[oldest_reg];
    end

    assign old1     = ees_pkg::sample_t'(win_q_reg[SAMP_W-1:0]);
    assign old2     = ees_pkg::sample_t'(win_q_reg[2*SAMP_W-1:SAMP_W]);
    assign old1_ext = win_full ? SUM_W'(old1) : '0;
    assign old2_ext = win_full ? SUM_W'(old2) : '0;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_POS1:
            begin
                posa_reg  <= cnt_val;
                samp1_reg <= ees_pkg::make_sample(mul_reg, dir1_reg);
                part1_reg <= sum1_reg - old1_ext;
                part2_reg <= sum2_reg - old2_ext;
            end
            ST_POS2:
            begin
                pos1_reg  <= posa_reg + cnt_val;
                samp2_reg <= ees_pkg::make_sample(mul_reg, dir2_reg);
            end
            ST_POS3:
            begin
                posa_reg <= cnt_val;
            end
            ST_POS4:
            begin
                pos2_reg <= posa_reg + cnt_val;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum1_reg   <= '0;
            sum2_reg   <= '0;
            fill_reg   <= '0;
            oldest_reg <= '0;
        end
        else if (state_reg == ST_POS3)
        begin
            sum1_reg <= part1_reg + SUM_W'(samp1_reg);
            sum2_reg <= part2_reg + SUM_W'(samp2_reg);
            if (win_full)
                oldest_reg <= (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + SLOT_W'(1);
            else
                fill_reg <= fill_reg + FILL_W'(1);
        end
    end

    // averages
    assign div_start = state_reg == ST_POS4;

    ees_div #(
        .NUM_W (SUM_W),
        .DEN_W (FILL_W)
    ) u_div1 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sum1_reg),
        .den   (fill_reg),
        .busy  (div1_busy),
        .quo   (div1_quo)
    );

    ees_div #(
        .NUM_W (SUM_W),
        .DEN_W (FILL_W)
    ) u_div2 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sum2_reg),
        .den   (fill_reg),
        .busy  (div2_busy),
        .quo   (div2_quo)
    );

    // output register
    assign out_load = (state_reg == ST_WAIT) && !div1_busy && !div2_busy
                   && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            avg1_reg  <= div1_quo;
            avg2_reg  <= div2_quo;
            opos1_reg <= pos1_reg;
            opos2_reg <= pos2_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign speed_avg_1 = avg1_reg;
    assign speed_avg_2 = avg2_reg;
    assign position_1  = signed'(opos1_reg);
    assign position_2  = signed'(opos2_reg);

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WINDOW))
        else $error("window fill level beyond window length");

    a_oldest_until_full: assert property (@(posedge clk) disable iff (!rst_n)
        !win_full |-> (oldest_reg == '0))
        else $error("oldest slot moved before the window filled");

    a_div_free_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (!div1_busy && !div2_busy))
        else $error("divider started while busy");

    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (div1_busy && div2_busy && state_reg == ST_WAIT))
        else $error("dividers did not start on a tick");

    a_edge_written: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EDGE) |=> cnt_vld_reg[$past(cnt_waddr_reg)])
        else $error("edge count not marked written");

endmodule
